// ===== hw/rtl/lamm_pkg.sv =====
// shared types, constants and codes for the linked array multimap
`default_nettype none

package lamm_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int LINK_W       = 7;
	localparam int DATA_W       = 32;
	localparam int CNT_W        = 7;

	typedef logic [LINK_W-1:0] link_t;
	typedef logic [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// all-ones link code ends a chain
	localparam link_t LINK_NULL = '1;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SEARCH = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_LINK,
		ST_ADD_WALK,
		ST_REM_WALK,
		ST_REM_FREE,
		ST_SRCH_WALK,
		ST_EMIT
	} state_t;

	// sequencer to slot store
	typedef struct packed {
		logic  rd_en;
		link_t rd_addr;
		logic  kv_we;
		link_t kv_addr;
		data_t kv_key;
		data_t kv_value;
		logic  link_we;
		link_t link_addr;
		link_t link_data;
	} mem_req_t;

	// registered read data of one slot
	typedef struct packed {
		data_t key;
		data_t value;
		link_t link;
	} mem_rsp_t;

	// result offered to the output register
	typedef struct packed {
		logic    valid;
		status_t status;
		data_t   found_value;
		logic    last;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/linked_array_multimap.sv =====
// top level of the linked array multimap: sequencer, slot store and result register
// add takes a slot off the free list, then walks the list to its tail; remove walks
//   entries until a match, then frees that slot; search walks every entry; a full add,
//   unused code or empty map goes straight to the result; all wait on result stalls
// throughput: one request at a time, one list entry per cycle from the single read port
//   of the link memory, while no search result stalls
// reset: empty map, free list chained in slot order, no result pending
`default_nettype none

module linked_array_multimap #(
	parameter int CAPACITY = lamm_pkg::CAPACITY_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic [1:0]            req_type,
	input  wire logic signed [31:0]    key,
	input  wire logic signed [31:0]    value,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output logic [1:0]                 status,
	output logic signed [31:0]         found_value,
	output logic                       last,
	output logic [6:0]                 entry_count,
	output logic                       empty_res
);

	lamm_pkg::mem_req_t mem_req;
	lamm_pkg::mem_rsp_t mem_rsp;
	lamm_pkg::res_t     push;
	lamm_pkg::cnt_t     count;
	logic               push_ok;

	logic               res_valid_q;
	logic [1:0]         status_q;
	logic signed [31:0] found_value_q;
	logic               last_q;
	logic [6:0]         entry_count_q;
	logic               empty_q;

	lamm_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.key       (key),
		.value     (value),
		.mem_req   (mem_req),
		.mem_rsp   (mem_rsp),
		.push      (push),
		.push_ok   (push_ok),
		.count     (count)
	);

	lamm_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rsp    (mem_rsp)
	);

	// result register frees when empty or being taken
	assign push_ok = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push.valid && push_ok) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid && push_ok) begin
			status_q      <= push.status;
			found_value_q <= push.found_value;
			last_q        <= push.last;
			entry_count_q <= count;
			empty_q       <= (count == '0);
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign found_value = found_value_q;
	assign last        = last_q;
	assign entry_count = entry_count_q;
	assign empty_res   = empty_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lamm_store.sv =====
// slot store: key, value and link memories with one read and one write port each
`default_nettype none

module lamm_store #(
	parameter int CAPACITY = lamm_pkg::CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lamm_pkg::mem_req_t req,
	output lamm_pkg::mem_rsp_t      rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [AW:0] CAP_C = (AW+1)'(CAPACITY);

	lamm_pkg::data_t key_mem   [CAPACITY];
	lamm_pkg::data_t value_mem [CAPACITY];
	lamm_pkg::link_t link_mem  [CAPACITY];

	logic [CAPACITY-1:0] link_vld_q;
	lamm_pkg::data_t     rd_key_q;
	lamm_pkg::data_t     rd_value_q;
	lamm_pkg::link_t     rd_link_q;
	logic                rd_vld_q;
	logic [AW-1:0]       rd_addr_q;
	logic [AW:0]         nxt_slot;
	lamm_pkg::link_t     dflt_link;

	always_ff @(posedge clk) begin
		if (req.kv_we) begin
			key_mem[req.kv_addr[AW-1:0]]   <= req.kv_key;
			value_mem[req.kv_addr[AW-1:0]] <= req.kv_value;
		end
		if (req.link_we) begin
			link_mem[req.link_addr[AW-1:0]] <= req.link_data;
		end
		if (req.rd_en) begin
			rd_key_q   <= key_mem[req.rd_addr[AW-1:0]];
			rd_value_q <= value_mem[req.rd_addr[AW-1:0]];
			rd_link_q  <= link_mem[req.rd_addr[AW-1:0]];
			rd_vld_q   <= link_vld_q[req.rd_addr[AW-1:0]];
			rd_addr_q  <= req.rd_addr[AW-1:0];
		end
	end

	// links never written read as the chained free list of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
		end else if (req.link_we) begin
			link_vld_q[req.link_addr[AW-1:0]] <= 1'b1;
		end
	end

	always_comb begin
		nxt_slot  = {1'b0, rd_addr_q} + (AW+1)'(1);
		dflt_link = (nxt_slot < CAP_C) ? lamm_pkg::LINK_W'(nxt_slot) : lamm_pkg::LINK_NULL;
		rsp.key   = rd_key_q;
		rsp.value = rd_value_q;
		rsp.link  = rd_vld_q ? rd_link_q : dflt_link;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lamm_ctrl.sv =====
// sequencer: walks a slot a cycle unless results stall; shared key/value comparator
`default_nettype none

module lamm_ctrl #(
	parameter int CAPACITY = lamm_pkg::CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire logic [1:0]         req_type,
	input  wire lamm_pkg::data_t    key,
	input  wire lamm_pkg::data_t    value,
	output lamm_pkg::mem_req_t      mem_req,
	input  wire lamm_pkg::mem_rsp_t mem_rsp,
	output lamm_pkg::res_t          push,
	input  wire logic               push_ok,
	output lamm_pkg::cnt_t          count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam lamm_pkg::link_t LINK_CAP = lamm_pkg::LINK_W'(CAPACITY);
	localparam lamm_pkg::cnt_t  CNT_CAP  = lamm_pkg::CNT_W'(CAPACITY);
	localparam logic [AW-1:0]   LAST_STEP = AW'(CAPACITY - 1);

	lamm_pkg::state_t  state_q, state_d;
	lamm_pkg::data_t   key_q, key_d;
	lamm_pkg::data_t   val_q, val_d;
	lamm_pkg::link_t   list_head_q, list_head_d;
	lamm_pkg::link_t   free_head_q, free_head_d;
	lamm_pkg::cnt_t    count_q, count_d;
	lamm_pkg::link_t   cur_q, cur_d;
	lamm_pkg::link_t   prev_q, prev_d;
	lamm_pkg::link_t   slot_q, slot_d;
	logic [AW-1:0]     steps_q, steps_d;
	logic              hit_q, hit_d;
	lamm_pkg::data_t   pend_q, pend_d;
	lamm_pkg::status_t res_status_q, res_status_d;
	lamm_pkg::data_t   res_val_q, res_val_d;

	logic key_eq;
	logic pair_eq;
	logic link_end;
	logic walk_done;
	logic stall;

	function automatic logic is_slot(input lamm_pkg::link_t p);
		return p < LINK_CAP;
	endfunction

	assign count = count_q;

	// the one comparator shared by the remove and search walks
	assign key_eq    = (mem_rsp.key == key_q);
	assign pair_eq   = key_eq && (mem_rsp.value == val_q);
	assign link_end  = !is_slot(mem_rsp.link);
	assign walk_done = link_end || (steps_q == LAST_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lamm_pkg::ST_IDLE;
			list_head_q <= lamm_pkg::LINK_NULL;
			free_head_q <= '0;
			count_q     <= '0;
			hit_q       <= 1'b0;
		end else begin
			state_q     <= state_d;
			list_head_q <= list_head_d;
			free_head_q <= free_head_d;
			count_q     <= count_d;
			hit_q       <= hit_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q        <= key_d;
		val_q        <= val_d;
		cur_q        <= cur_d;
		prev_q       <= prev_d;
		slot_q       <= slot_d;
		steps_q      <= steps_d;
		pend_q       <= pend_d;
		res_status_q <= res_status_d;
		res_val_q    <= res_val_d;
	end

	always_comb begin
		state_d      = state_q;
		key_d        = key_q;
		val_d        = val_q;
		list_head_d  = list_head_q;
		free_head_d  = free_head_q;
		count_d      = count_q;
		cur_d        = cur_q;
		prev_d       = prev_q;
		slot_d       = slot_q;
		steps_d      = steps_q;
		hit_d        = hit_q;
		pend_d       = pend_q;
		res_status_d = res_status_q;
		res_val_d    = res_val_q;
		req_ready    = 1'b0;
		mem_req      = '0;
		mem_req.kv_key   = key_q;
		mem_req.kv_value = val_q;
		push         = '0;
		stall        = 1'b0;

		case (state_q)
			lamm_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					key_d     = key;
					val_d     = value;
					steps_d   = '0;
					res_val_d = '0;
					case (req_type)
						lamm_pkg::REQ_ADD: begin
							if (count_q >= CNT_CAP || !is_slot(free_head_q)) begin
								res_status_d = lamm_pkg::STAT_FULL;
								state_d      = lamm_pkg::ST_EMIT;
							end else begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = free_head_q;
								slot_d          = free_head_q;
								state_d         = lamm_pkg::ST_ADD_LINK;
							end
						end
						lamm_pkg::REQ_REMOVE: begin
							if (!is_slot(list_head_q)) begin
								res_status_d = lamm_pkg::STAT_MISS;
								state_d      = lamm_pkg::ST_EMIT;
							end else begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = list_head_q;
								cur_d           = list_head_q;
								prev_d          = lamm_pkg::LINK_NULL;
								state_d         = lamm_pkg::ST_REM_WALK;
							end
						end
						lamm_pkg::REQ_SEARCH: begin
							if (!is_slot(list_head_q)) begin
								res_status_d = lamm_pkg::STAT_MISS;
								state_d      = lamm_pkg::ST_EMIT;
							end else begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = list_head_q;
								hit_d           = 1'b0;
								state_d         = lamm_pkg::ST_SRCH_WALK;
							end
						end
						default: begin
							res_status_d = lamm_pkg::STAT_MISS;
							state_d      = lamm_pkg::ST_EMIT;
						end
					endcase
				end
			end

			lamm_pkg::ST_ADD_LINK: begin
				// take the slot off the free list and fill it
				free_head_d       = mem_rsp.link;
				mem_req.kv_we     = 1'b1;
				mem_req.kv_addr   = slot_q;
				mem_req.link_we   = 1'b1;
				mem_req.link_addr = slot_q;
				mem_req.link_data = lamm_pkg::LINK_NULL;
				if (!is_slot(list_head_q)) begin
					list_head_d  = slot_q;
					count_d      = count_q + lamm_pkg::CNT_W'(1);
					res_status_d = lamm_pkg::STAT_OK;
					state_d      = lamm_pkg::ST_EMIT;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = list_head_q;
					cur_d           = list_head_q;
					state_d         = lamm_pkg::ST_ADD_WALK;
				end
			end

			lamm_pkg::ST_ADD_WALK: begin
				if (walk_done) begin
					// walk ends at the tail, or at the step bound on the slot the last read links to
					mem_req.link_we   = 1'b1;
					mem_req.link_addr = link_end ? cur_q : mem_rsp.link;
					mem_req.link_data = slot_q;
					count_d           = count_q + lamm_pkg::CNT_W'(1);
					res_status_d      = lamm_pkg::STAT_OK;
					state_d           = lamm_pkg::ST_EMIT;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = mem_rsp.link;
					cur_d           = mem_rsp.link;
					steps_d         = steps_q + AW'(1);
				end
			end

			lamm_pkg::ST_REM_WALK: begin
				if (pair_eq) begin
					if (is_slot(prev_q)) begin
						mem_req.link_we   = 1'b1;
						mem_req.link_addr = prev_q;
						mem_req.link_data = mem_rsp.link;
					end else begin
						list_head_d = mem_rsp.link;
					end
					state_d = lamm_pkg::ST_REM_FREE;
				end else if (walk_done) begin
					res_status_d = lamm_pkg::STAT_MISS;
					state_d      = lamm_pkg::ST_EMIT;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = mem_rsp.link;
					prev_d          = cur_q;
					cur_d           = mem_rsp.link;
					steps_d         = steps_q + AW'(1);
				end
			end

			lamm_pkg::ST_REM_FREE: begin
				mem_req.link_we   = 1'b1;
				mem_req.link_addr = cur_q;
				mem_req.link_data = free_head_q;
				free_head_d       = cur_q;
				if (count_q != '0) begin
					count_d = count_q - lamm_pkg::CNT_W'(1);
				end
				res_status_d = lamm_pkg::STAT_OK;
				state_d      = lamm_pkg::ST_EMIT;
			end

			lamm_pkg::ST_SRCH_WALK: begin
				// a hit is held back until the next one shows whether it is the last
				if (key_eq && hit_q) begin
					push.valid       = 1'b1;
					push.status      = lamm_pkg::STAT_OK;
					push.found_value = pend_q;
					push.last        = 1'b0;
					stall            = !push_ok;
				end
				if (!stall) begin
					if (key_eq) begin
						pend_d = mem_rsp.value;
						hit_d  = 1'b1;
					end
					if (walk_done) begin
						res_status_d = (key_eq || hit_q) ? lamm_pkg::STAT_OK : lamm_pkg::STAT_MISS;
						res_val_d    = key_eq ? mem_rsp.value : (hit_q ? pend_q : '0);
						state_d      = lamm_pkg::ST_EMIT;
					end else begin
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = mem_rsp.link;
						steps_d         = steps_q + AW'(1);
					end
				end
			end

			lamm_pkg::ST_EMIT: begin
				push.valid       = 1'b1;
				push.status      = res_status_q;
				push.found_value = res_val_q;
				push.last        = 1'b1;
				if (push_ok) begin
					state_d = lamm_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = lamm_pkg::ST_IDLE;
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_CAP)
		else $error("pair count above capacity");

	// the count is updated in the cycle after the head while a slot is being freed
	a_head_vs_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lamm_pkg::ST_REM_FREE) |->
		((count_q == '0) == (list_head_q >= LINK_CAP)))
		else $error("list head disagrees with pair count");

	a_full_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CNT_CAP) |-> (free_head_q >= LINK_CAP))
		else $error("free list not empty on a full map");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != lamm_pkg::ST_IDLE))
		else $error("request accepted without leaving idle");

endmodule

`default_nettype wire

// ===== verif/tb_linked_array_multimap.sv =====
// testbench for the linked array multimap: directed table, random traffic, scoreboard
`default_nettype none

module tb_linked_array_multimap;
	import lamm_pkg::*;

	localparam int          CAP            = CAPACITY_DEF;
	localparam logic [1:0]  REQ_UNUSED     = 2'd3;
	localparam data_t       KEY_MIN        = 32'h8000_0000;
	localparam data_t       KEY_MAX        = 32'h7fff_ffff;
	localparam data_t       HOT_KEY        = 32'h0000_002a;
	localparam int          WATCHDOG_LIMIT = 5000;
	localparam int          DRAIN_CYCLES   = 80;

	typedef struct packed {
		status_t status;
		data_t   found;
		logic    last;
		cnt_t    count;
		logic    empty;
	} map_result_t;

	typedef struct {
		logic [1:0] op;
		data_t      k;
		data_t      v;
		bit         typed;
		status_t    st;
		cnt_t       cnt;
	} stim_row_t;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               req_valid   = 1'b0;
	logic               req_ready;
	logic [1:0]         req_type    = REQ_ADD;
	logic signed [31:0] key         = '0;
	logic signed [31:0] value       = '0;
	logic               res_valid;
	logic               res_ready   = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] found_value;
	logic               last;
	logic [6:0]         entry_count;
	logic               empty_res;

	// predicted contents of the map
	data_t map_key [CAP];
	data_t map_val [CAP];
	link_t map_link[CAP];
	link_t map_head;
	link_t map_free;
	int    map_count;

	map_result_t awaited_results[$];
	map_result_t fresh_results[$];
	stim_row_t   stim_rows[$];

	bit no_idle    = 1'b0;
	int errors     = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	linked_array_multimap u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.key         (key),
		.value       (value),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.status      (status),
		.found_value (found_value),
		.last        (last),
		.entry_count (entry_count),
		.empty_res   (empty_res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 93)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic data_t pick_word();
		case ($urandom_range(0, 9))
			0: return KEY_MIN;
			1: return KEY_MAX;
			2: return '0;
			3: return '1;
			4: return 32'd1;
			5: return 32'h5a5a_a5a5;
			6, 7: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic void put_result(status_t st, data_t fv, logic lst);
		map_result_t r;
		r.status = st;
		r.found  = fv;
		r.last   = lst;
		r.count  = map_count[6:0];
		r.empty  = (map_count == 0);
		fresh_results.insert(fresh_results.size(), r);
	endfunction

	function automatic void clear_map();
		for (int i = 0; i < CAP; i++) begin
			map_key[i]  = '0;
			map_val[i]  = '0;
			map_link[i] = (i + 1 < CAP) ? link_t'(i + 1) : LINK_NULL;
		end
		map_head  = LINK_NULL;
		map_free  = '0;
		map_count = 0;
	endfunction

	// slot of the n-th pair in list order
	function automatic link_t nth_entry(int n);
		link_t cur;
		cur = map_head;
		repeat (n) cur = map_link[cur];
		return cur;
	endfunction

	// updates the predicted map and leaves the results of one request in fresh_results
	function automatic void predict_request(logic [1:0] op, data_t k, data_t v);
		link_t slot;
		link_t cur;
		link_t prev;
		bit    hit;
		data_t hits[$];
		fresh_results.delete();
		case (op)
			REQ_ADD: begin
				if (map_count >= CAP || map_free >= CAP) begin
					put_result(STAT_FULL, '0, 1'b1);
				end else begin
					slot           = map_free;
					map_free       = map_link[slot];
					map_key[slot]  = k;
					map_val[slot]  = v;
					map_link[slot] = LINK_NULL;
					if (map_head >= CAP) begin
						map_head = slot;
					end else begin
						cur = map_head;
						for (int s = 0; s < CAP; s++) begin
							if (map_link[cur] >= CAP)
								break;
							cur = map_link[cur];
						end
						map_link[cur] = slot;
					end
					map_count++;
					put_result(STAT_OK, '0, 1'b1);
				end
			end
			REQ_REMOVE: begin
				cur  = map_head;
				prev = LINK_NULL;
				hit  = 1'b0;
				for (int s = 0; s < CAP && cur < CAP && !hit; s++) begin
					if (map_key[cur] == k && map_val[cur] == v) begin
						hit = 1'b1;
						if (prev < CAP)
							map_link[prev] = map_link[cur];
						else
							map_head = map_link[cur];
						map_link[cur] = map_free;
						map_free      = cur;
						if (map_count > 0)
							map_count--;
					end else begin
						prev = cur;
						cur  = map_link[cur];
					end
				end
				put_result(hit ? STAT_OK : STAT_MISS, '0, 1'b1);
			end
			REQ_SEARCH: begin
				cur = map_head;
				for (int s = 0; s < CAP && cur < CAP; s++) begin
					if (map_key[cur] == k)
						hits.insert(hits.size(), map_val[cur]);
					cur = map_link[cur];
				end
				if (hits.size() == 0)
					put_result(STAT_MISS, '0, 1'b1);
				for (int i = 0; i < hits.size(); i++)
					put_result(STAT_OK, hits[i], i == hits.size() - 1);
			end
			default: begin
				put_result(STAT_MISS, '0, 1'b1);
			end
		endcase
	endfunction

	function automatic void add_row(logic [1:0] op, data_t k, data_t v, bit typed,
			status_t st, cnt_t cnt);
		stim_row_t row;
		row.op    = op;
		row.k     = k;
		row.v     = v;
		row.typed = typed;
		row.st    = st;
		row.cnt   = cnt;
		stim_rows.insert(stim_rows.size(), row);
	endfunction

	task automatic send_request(input logic [1:0] op, input data_t k, input data_t v,
			input bit typed, input status_t st, input cnt_t cnt);
		int          g;
		map_result_t r;
		if (!no_idle && $urandom_range(0, 99) < 30) begin
			g = pick_gap();
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= op;
		key       <= k;
		value     <= v;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predict_request(op, k, v);
		if (typed) begin
			r.status = st;
			r.found  = '0;
			r.last   = 1'b1;
			r.count  = cnt;
			r.empty  = (cnt == 0);
			awaited_results.insert(awaited_results.size(), r);
		end else begin
			foreach (fresh_results[i])
				awaited_results.insert(awaited_results.size(), fresh_results[i]);
		end
	endtask

	task automatic issue(input logic [1:0] op, input data_t k, input data_t v);
		send_request(op, k, v, 1'b0, STAT_OK, '0);
	endtask

	// sender holds off until every pending result has been taken
	task automatic hold_until_drained();
		if (awaited_results.size() != 0) begin
			req_valid <= 1'b0;
			while (awaited_results.size() != 0) @(posedge clk);
		end
	endtask

	task automatic random_item(input int add_pct);
		int         r;
		link_t      p;
		logic [1:0] op;
		data_t      k;
		data_t      v;
		r = $urandom_range(0, 99);
		k = pick_word();
		v = pick_word();
		if (r < add_pct) begin
			op = REQ_ADD;
		end else if (r < add_pct + 25) begin
			op = REQ_REMOVE;
			if (map_count > 0 && $urandom_range(0, 3) != 0) begin
				p = nth_entry($urandom_range(0, map_count - 1));
				k = map_key[p];
				v = map_val[p];
			end
		end else if (r < 92) begin
			op = REQ_SEARCH;
			if (map_count > 0 && $urandom_range(0, 9) < 7) begin
				p = nth_entry($urandom_range(0, map_count - 1));
				k = map_key[p];
			end
		end else if (r < 96) begin
			op = REQ_UNUSED;
			k  = $urandom;
			v  = $urandom;
		end else begin
			op = 2'($urandom_range(0, 2));
			k  = $urandom;
			v  = $urandom;
		end
		issue(op, k, v);
	endtask

	// result side: scoreboard and random backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result status %0d value %0d last %0d count %0d",
						$time, status, found_value, last, entry_count);
				end else begin
					if (status !== awaited_results[0].status
							|| found_value !== awaited_results[0].found
							|| last !== awaited_results[0].last
							|| entry_count !== awaited_results[0].count
							|| empty_res !== awaited_results[0].empty) begin
						errors++;
						$display("%0t: mismatch expected st %0d val %0d last %0d cnt %0d emp %0d",
							$time, awaited_results[0].status,
							$signed(awaited_results[0].found), awaited_results[0].last,
							awaited_results[0].count, awaited_results[0].empty);
						$display("%0t:          actual   st %0d val %0d last %0d cnt %0d emp %0d",
							$time, status, found_value, last, entry_count, empty_res);
					end
					void'(awaited_results.pop_front());
				end
			end
			if (no_idle) begin
				res_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < 25) begin
				stall_left = pick_gap() - 1;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no request or result taken
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (res_valid && res_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("tb_linked_array_multimap: done, errors");
				$finish;
			end
		end
	end

	initial begin
		clear_map();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty map, extremes, duplicates, key hit with value miss, head/middle/tail removal
		add_row(REQ_SEARCH, 32'd5, 32'd0, 1'b1, STAT_MISS, 7'd0);
		add_row(REQ_REMOVE, 32'd5, 32'd1, 1'b1, STAT_MISS, 7'd0);
		add_row(REQ_UNUSED, 32'd0, 32'd0, 1'b1, STAT_MISS, 7'd0);
		add_row(REQ_ADD, KEY_MIN, KEY_MAX, 1'b1, STAT_OK, 7'd1);
		add_row(REQ_ADD, KEY_MAX, KEY_MIN, 1'b1, STAT_OK, 7'd2);
		add_row(REQ_ADD, KEY_MIN, 32'd0, 1'b1, STAT_OK, 7'd3);
		add_row(REQ_ADD, 32'd0, '1, 1'b1, STAT_OK, 7'd4);
		add_row(REQ_ADD, KEY_MIN, KEY_MAX, 1'b1, STAT_OK, 7'd5);
		add_row(REQ_SEARCH, KEY_MIN, 32'd0, 1'b0, STAT_OK, 7'd0);
		add_row(REQ_SEARCH, KEY_MAX, '1, 1'b0, STAT_OK, 7'd0);
		add_row(REQ_SEARCH, 32'd0, 32'h5a5a_a5a5, 1'b0, STAT_OK, 7'd0);
		add_row(REQ_SEARCH, 32'd7, 32'd0, 1'b1, STAT_MISS, 7'd5);
		add_row(REQ_REMOVE, KEY_MIN, 32'd1, 1'b1, STAT_MISS, 7'd5);
		add_row(REQ_REMOVE, KEY_MAX, 32'd0, 1'b1, STAT_MISS, 7'd5);
		add_row(REQ_REMOVE, KEY_MIN, KEY_MAX, 1'b1, STAT_OK, 7'd4);
		add_row(REQ_SEARCH, KEY_MIN, 32'd0, 1'b0, STAT_OK, 7'd0);
		add_row(REQ_UNUSED, '1, '1, 1'b1, STAT_MISS, 7'd4);
		add_row(REQ_REMOVE, KEY_MIN, KEY_MAX, 1'b1, STAT_OK, 7'd3);
		add_row(REQ_REMOVE, KEY_MIN, KEY_MAX, 1'b1, STAT_MISS, 7'd3);
		add_row(REQ_REMOVE, KEY_MAX, KEY_MIN, 1'b1, STAT_OK, 7'd2);
		add_row(REQ_ADD, 32'd1, 32'd2, 1'b1, STAT_OK, 7'd3);
		add_row(REQ_SEARCH, 32'd1, 32'd0, 1'b0, STAT_OK, 7'd0);
		add_row(REQ_REMOVE, 32'd0, '1, 1'b1, STAT_OK, 7'd2);
		add_row(REQ_REMOVE, KEY_MIN, 32'd0, 1'b1, STAT_OK, 7'd1);
		add_row(REQ_REMOVE, 32'd1, 32'd2, 1'b1, STAT_OK, 7'd0);
		foreach (stim_rows[i])
			send_request(stim_rows[i].op, stim_rows[i].k, stim_rows[i].v,
				stim_rows[i].typed, stim_rows[i].st, stim_rows[i].cnt);
		hold_until_drained();

		// mixed traffic, kept away from full
		for (int i = 0; i < 150; i++) begin
			if (i == 60)
				no_idle = 1'b1;
			if (i == 90)
				no_idle = 1'b0;
			random_item(map_count > 48 ? 20 : 45);
		end

		// fill to capacity, mostly under one key so one search returns many values
		while (map_count < CAP)
			issue(REQ_ADD, ($urandom_range(0, 4) != 0) ? HOT_KEY : pick_word(), $urandom);
		repeat (3) issue(REQ_ADD, pick_word(), pick_word());
		issue(REQ_SEARCH, HOT_KEY, $urandom);
		issue(REQ_SEARCH, KEY_MAX, '0);
		random_item(0);
		issue(REQ_ADD, HOT_KEY, KEY_MIN);
		issue(REQ_ADD, HOT_KEY, KEY_MAX);
		hold_until_drained();
		for (int i = 0; i < 20; i++)
			random_item(0);
		issue(REQ_SEARCH, HOT_KEY, '1);

		for (int i = 0; i < 110; i++) begin
			no_idle = (i >= 30 && i < 55);
			random_item(map_count > 48 ? 20 : 40);
		end
		no_idle = 1'b0;

		req_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_linked_array_multimap: done, clean");
		else
			$display("tb_linked_array_multimap: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
